/* hdl/tcpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types for the two-class priority queue
// Request and result payloads, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package tcpq_pkg;

	// default storage sizes
	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;

	// fixed field widths of the ports
	localparam int WORD_W = 32;
	localparam int ENT_W  = 5;

	// operation codes
	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	// status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// request payload
	typedef struct packed {
		op_t               operation;
		logic              priority_low;
		logic [WORD_W-1:0] data_in;
	} req_t;

	// result payload
	typedef struct packed {
		logic [WORD_W-1:0] data_out;
		logic              data_valid;
		status_t           status;
		logic [ENT_W-1:0]  high_entries;
		logic [ENT_W-1:0]  low_entries;
		logic              queue_empty;
	} rsp_t;

endpackage

/* hdl/two_class_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_queue: bounded queue with a high and a low class
// Each class keeps its words in a ring memory; dequeue prefers the high class.
// ----------------------------------------------------------------------------
// Usage
//   A request (enqueue or dequeue) is taken at a rising edge with start high
//   and busy low. busy stays low: the block takes one request every cycle.
//   Each request gives exactly one result on rsp, marked by done for one
//   cycle, in the cycle after the request is taken.
//   The result carries the dequeued word (zero if none), a status code and
//   both class counts after the request.
//   Class counts and pointers are decided in the request cycle; a dequeue
//   reads its class memory at the request edge and the registered read data
//   forms data_out. Throughput is one request per cycle, set by the single
//   write and read port of each class memory.
//   An enqueue into a full class is dropped with status full; a dequeue with
//   both classes empty returns status empty.
//   Reset clears pointers, counts and the result strobe; memory contents are
//   not cleared and are never read before being written.
//   The receiver cannot stall: each result must be taken in its cycle.
// ----------------------------------------------------------------------------
module two_class_priority_queue
	import tcpq_pkg::*;
#(
	parameter int DEPTH  = DEPTH_DEF,
	parameter int DATA_W = DATA_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	// class memories
	logic [DATA_W-1:0] high_mem [DEPTH];
	logic [DATA_W-1:0] low_mem  [DEPTH];

	logic [PTR_W-1:0] high_rd_ptr_q, high_wr_ptr_q, low_rd_ptr_q, low_wr_ptr_q;
	logic [CNT_W-1:0] high_cnt_q, low_cnt_q;
	logic [CNT_W-1:0] high_cnt_d, low_cnt_d;

	logic accept;
	logic enq_high, enq_low, deq_high, deq_low;
	status_t status_d;

	logic [DATA_W-1:0] wr_word;
	logic [63:0]       in_ext;

	logic              done_s1;
	logic              valid_s1;
	logic              from_high_s1;
	status_t           status_s1;
	logic [ENT_W-1:0]  high_ent_s1, low_ent_s1;
	logic              empty_s1;
	logic [DATA_W-1:0] high_rd_s1, low_rd_s1;

	logic [DATA_W-1:0] rd_word;
	logic [63:0]       out_ext;
	logic [15:0]       high_cnt_ext, low_cnt_ext;

	// every request completes in one pass
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// fit the request word to the stored width
	assign in_ext  = 64'(req.data_in);
	assign wr_word = in_ext[DATA_W-1:0];

	// request decode and class selection
	always_comb begin
		enq_high = 1'b0;
		enq_low  = 1'b0;
		deq_high = 1'b0;
		deq_low  = 1'b0;
		status_d = ST_OK;
		if (accept) begin
			case (req.operation)
				OP_ENQ: begin
					if (!req.priority_low) begin
						if (high_cnt_q == CNT_FULL) status_d = ST_FULL;
						else enq_high = 1'b1;
					end else begin
						if (low_cnt_q == CNT_FULL) status_d = ST_FULL;
						else enq_low = 1'b1;
					end
				end
				OP_DEQ: begin
					if (high_cnt_q != '0) deq_high = 1'b1;
					else if (low_cnt_q != '0) deq_low = 1'b1;
					else status_d = ST_EMPTY;
				end
				default: status_d = ST_OK;
			endcase
		end
	end

	// next class counts
	always_comb begin
		high_cnt_d = high_cnt_q;
		low_cnt_d  = low_cnt_q;
		if (enq_high) high_cnt_d = high_cnt_q + 1'b1;
		if (deq_high) high_cnt_d = high_cnt_q - 1'b1;
		if (enq_low)  low_cnt_d  = low_cnt_q + 1'b1;
		if (deq_low)  low_cnt_d  = low_cnt_q - 1'b1;
	end

	assign high_cnt_ext = 16'(high_cnt_d);
	assign low_cnt_ext  = 16'(low_cnt_d);

	// pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_rd_ptr_q <= '0;
			high_wr_ptr_q <= '0;
			low_rd_ptr_q  <= '0;
			low_wr_ptr_q  <= '0;
			high_cnt_q    <= '0;
			low_cnt_q     <= '0;
		end else begin
			high_cnt_q <= high_cnt_d;
			low_cnt_q  <= low_cnt_d;
			if (enq_high)
				high_wr_ptr_q <= (high_wr_ptr_q == PTR_LAST) ? '0 : high_wr_ptr_q + 1'b1;
			if (deq_high)
				high_rd_ptr_q <= (high_rd_ptr_q == PTR_LAST) ? '0 : high_rd_ptr_q + 1'b1;
			if (enq_low)
				low_wr_ptr_q <= (low_wr_ptr_q == PTR_LAST) ? '0 : low_wr_ptr_q + 1'b1;
			if (deq_low)
				low_rd_ptr_q <= (low_rd_ptr_q == PTR_LAST) ? '0 : low_rd_ptr_q + 1'b1;
		end
	end

	// high class memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (enq_high) high_mem[high_wr_ptr_q] <= wr_word;
		if (deq_high) high_rd_s1 <= high_mem[high_rd_ptr_q];
	end

	// low class memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (enq_low) low_mem[low_wr_ptr_q] <= wr_word;
		if (deq_low) low_rd_s1 <= low_mem[low_rd_ptr_q];
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// result fields held for the read cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			valid_s1     <= deq_high || deq_low;
			from_high_s1 <= deq_high;
			status_s1    <= status_d;
			high_ent_s1  <= high_cnt_ext[ENT_W-1:0];
			low_ent_s1   <= low_cnt_ext[ENT_W-1:0];
			empty_s1     <= (high_cnt_d == '0) && (low_cnt_d == '0);
		end
	end

	// pick the read word and fit it to the port width
	assign rd_word = from_high_s1 ? high_rd_s1 : low_rd_s1;
	assign out_ext = 64'(rd_word);

	// result assembly
	always_comb begin
		rsp.data_out     = valid_s1 ? out_ext[WORD_W-1:0] : '0;
		rsp.data_valid   = valid_s1;
		rsp.status       = status_s1;
		rsp.high_entries = high_ent_s1;
		rsp.low_entries  = low_ent_s1;
		rsp.queue_empty  = empty_s1;
	end

	assign done = done_s1;

endmodule
